// File: design/lmfb_pkg.sv
// Shared types, constants and the helper function of the LIN master frame builder.
`timescale 1ns / 1ps
`default_nettype none

package lmfb_pkg;

	localparam int ID_W        = 8;
	localparam int LEN_W       = 4;
	localparam int PAYLOAD_W   = 64;
	localparam int BYTE_W      = 8;
	localparam int S_TDATA_W   = 80;
	localparam int USER_W      = 2;
	localparam int MAX_DATA    = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
	localparam logic [BYTE_W-1:0] BREAK_BYTE = 8'h00;
	localparam logic [ID_W-1:0]   ID_MAX     = 8'h3f;

	localparam int USER_BREAK = 0;
	localparam int USER_BAD   = 1;

	typedef struct packed {
		logic                 bad;
		logic [BYTE_W-1:0]    pid;
		logic [LEN_W-1:0]     len;
		logic [PAYLOAD_W-1:0] payload;
	} req_t;

	function automatic logic [BYTE_W-1:0] protect_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

endpackage

`default_nettype wire

// File: design/lmfb_front.sv
// Front end: checks the identifier, adds parity and clamps the data length.
`timescale 1ns / 1ps
`default_nettype none

module lmfb_front #(
	parameter int MAX_DATA = lmfb_pkg::MAX_DATA
) (
	input  wire logic [lmfb_pkg::ID_W-1:0]      frame_id,
	input  wire logic [lmfb_pkg::LEN_W-1:0]     data_len,
	input  wire logic [lmfb_pkg::PAYLOAD_W-1:0] payload,
	output lmfb_pkg::req_t                      req
);

	localparam logic [lmfb_pkg::LEN_W-1:0] LEN_MAX = lmfb_pkg::LEN_W'(MAX_DATA);

	always_comb begin
		req.bad     = frame_id > lmfb_pkg::ID_MAX;
		req.pid     = lmfb_pkg::protect_id(frame_id[5:0]);
		req.len     = (data_len > LEN_MAX) ? LEN_MAX : data_len;
		req.payload = payload;
	end

endmodule

`default_nettype wire

// File: design/lmfb_queue.sv
// Short request queue between the front end and the serializer.
`timescale 1ns / 1ps
`default_nettype none

module lmfb_queue #(
	parameter int DEPTH = lmfb_pkg::QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire lmfb_pkg::req_t push_data,
	output logic          full,
	input  wire logic     pop,
	output logic          nonempty,
	output lmfb_pkg::req_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	lmfb_pkg::req_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = count_q == CW'(DEPTH);
	assign nonempty = count_q != '0;
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty |-> !pop) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// File: design/lmfb_back.sv
// Serializer: emits the frame bytes one beat per cycle while the output is not stalled and builds the checksum.
`timescale 1ns / 1ps
`default_nettype none

module lmfb_back #(
	parameter int MAX_DATA = lmfb_pkg::MAX_DATA
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_nonempty,
	input  wire lmfb_pkg::req_t                q_head,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [lmfb_pkg::BYTE_W-1:0]        m_tdata,
	output logic [lmfb_pkg::USER_W-1:0]        m_tuser,
	output logic                               m_tlast
);

	localparam int CW = $clog2(MAX_DATA + 4);
	localparam logic [CW-1:0] SLOT_BREAK = CW'(0);
	localparam logic [CW-1:0] SLOT_SYNC  = CW'(1);
	localparam logic [CW-1:0] SLOT_PID   = CW'(2);
	localparam logic [CW-1:0] SLOT_DATA  = CW'(3);

	logic                              busy_q;
	logic [CW-1:0]                     slot_q;
	logic [lmfb_pkg::BYTE_W-1:0]       sum_q;
	logic [lmfb_pkg::PAYLOAD_W-1:0]    data_q;
	logic                              bad_q;
	logic [lmfb_pkg::BYTE_W-1:0]       pid_q;
	logic [lmfb_pkg::LEN_W-1:0]        len_q;

	logic                              out_valid_q;
	logic [lmfb_pkg::BYTE_W-1:0]       out_byte_q;
	logic                              out_brk_q;
	logic                              out_bad_q;
	logic                              out_last_q;

	logic                              adv;
	logic                              load;
	logic                              last_beat;
	logic                              data_beat;
	logic [CW-1:0]                     cks_slot;
	logic [lmfb_pkg::BYTE_W-1:0]       beat_byte;
	logic                              beat_brk;
	logic [lmfb_pkg::BYTE_W:0]         sum_wide;

	assign cks_slot  = CW'(len_q) + SLOT_DATA;
	assign data_beat = !bad_q && (slot_q >= SLOT_DATA) && (slot_q < cks_slot);
	assign last_beat = bad_q || ((len_q == '0) ? (slot_q == SLOT_PID) : (slot_q == cks_slot));
	assign sum_wide  = {1'b0, sum_q} + {1'b0, data_q[lmfb_pkg::BYTE_W-1:0]};

	always_comb begin
		beat_brk = 1'b0;
		if (bad_q) begin
			beat_byte = '0;
		end else if (slot_q == SLOT_BREAK) begin
			beat_byte = lmfb_pkg::BREAK_BYTE;
			beat_brk  = 1'b1;
		end else if (slot_q == SLOT_SYNC) begin
			beat_byte = lmfb_pkg::SYNC_BYTE;
		end else if (slot_q == SLOT_PID) begin
			beat_byte = pid_q;
		end else if (data_beat) begin
			beat_byte = data_q[lmfb_pkg::BYTE_W-1:0];
		end else begin
			beat_byte = ~sum_q;
		end
	end

	assign adv   = busy_q && (!out_valid_q || m_tready);
	assign load  = q_nonempty && (!busy_q || (adv && last_beat));
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (last_beat) begin
					busy_q <= 1'b0;
				end
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= beat_byte;
			out_brk_q  <= beat_brk;
			out_bad_q  <= bad_q;
			out_last_q <= last_beat;
			slot_q     <= slot_q + CW'(1);
			if (data_beat) begin
				data_q <= data_q >> lmfb_pkg::BYTE_W;
				sum_q  <= sum_wide[lmfb_pkg::BYTE_W-1:0]
					+ lmfb_pkg::BYTE_W'(sum_wide[lmfb_pkg::BYTE_W]);
			end
		end
		if (load) begin
			bad_q  <= q_head.bad;
			pid_q  <= q_head.pid;
			len_q  <= q_head.len;
			data_q <= q_head.payload;
			slot_q <= '0;
			sum_q  <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_bad_q, out_brk_q};
	assign m_tlast  = out_last_q;

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bad_q |-> out_last_q && !out_brk_q)
		else $error("error beat must end its request");
	a_break_first: assert property (@(posedge clk) disable iff (!arst_n)
		adv && beat_brk |-> !last_beat && slot_q == SLOT_BREAK)
		else $error("break slot out of place");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> slot_q <= cks_slot)
		else $error("slot counter ran past the checksum");
	a_load_refills: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && slot_q == SLOT_BREAK)
		else $error("request not taken up after load");

endmodule

`default_nettype wire

// File: design/lin_master_frame_builder_top.sv
// Top level of the LIN master frame builder.
// Each request beat (identifier, length, payload) becomes the byte stream of one LIN
// master frame: a break slot flagged in tuser, the sync byte, the protected identifier,
// the payload bytes and the inverted classic checksum, with tlast on the final byte.
// A length above MAX_DATA is clamped; an identifier above 63 yields one error beat.
// The serializer sends one byte per cycle while the output is not stalled; with length zero
// the identifier byte is the last (no checksum). Requests queue ahead of it, and the next
// frame follows the previous last byte without a gap if it is queued and the output does not stall.
`timescale 1ns / 1ps
`default_nettype none

module lin_master_frame_builder_top #(
	parameter int MAX_DATA    = lmfb_pkg::MAX_DATA,
	parameter int QUEUE_DEPTH = lmfb_pkg::QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// frame_id [7:0], data_len [11:8], payload [75:12], zero [79:76]
	input  wire logic [lmfb_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_byte [7:0]
	output logic [lmfb_pkg::BYTE_W-1:0]          m_tdata,
	// is_break [0], bad_id [1]
	output logic [lmfb_pkg::USER_W-1:0]          m_tuser,
	output logic                                 m_tlast
);

	lmfb_pkg::req_t req;
	lmfb_pkg::req_t q_head;
	logic           q_full;
	logic           q_nonempty;
	logic           q_pop;
	logic           push;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	lmfb_front #(
		.MAX_DATA(MAX_DATA)
	) u_front (
		.frame_id (s_tdata[7:0]),
		.data_len (s_tdata[11:8]),
		.payload  (s_tdata[75:12]),
		.req      (req)
	);

	lmfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (req),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	lmfb_back #(
		.MAX_DATA(MAX_DATA)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the LIN master frame builder: random and directed requests.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [lmfb_pkg::ID_W-1:0]      id;
		logic [lmfb_pkg::LEN_W-1:0]     len;
		logic [lmfb_pkg::PAYLOAD_W-1:0] payload;
	} frame_req_t;

	typedef struct {
		logic [lmfb_pkg::BYTE_W-1:0] data;
		logic                        brk;
		logic                        bad;
		logic                        last;
	} frame_beat_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [lmfb_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [lmfb_pkg::BYTE_W-1:0]    m_tdata;
	logic [lmfb_pkg::USER_W-1:0]    m_tuser;
	logic                           m_tlast;

	frame_req_t  requests[$];
	frame_beat_t beats_due[$];
	int          send_idx = 0;
	logic        req_taken = 1'b0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int          cycles = 0;

	lin_master_frame_builder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("tb: mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Expected byte stream of one request beat, appended to the queue of beats due.
	task automatic predict_frame(input logic [lmfb_pkg::S_TDATA_W-1:0] word);
		logic [lmfb_pkg::ID_W-1:0]   id;
		logic [lmfb_pkg::LEN_W-1:0]  n;
		logic [8:0]                  sum;
		logic [lmfb_pkg::BYTE_W-1:0] b;
		logic                        p0;
		logic                        p1;
		id = word[7:0];
		n = word[11:8];
		sum = '0;
		if (id > lmfb_pkg::ID_MAX) begin
			beats_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
			return;
		end
		if (n > lmfb_pkg::MAX_DATA)
			n = lmfb_pkg::LEN_W'(lmfb_pkg::MAX_DATA);
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		beats_due.push_back('{lmfb_pkg::BREAK_BYTE, 1'b1, 1'b0, 1'b0});
		beats_due.push_back('{lmfb_pkg::SYNC_BYTE, 1'b0, 1'b0, 1'b0});
		beats_due.push_back('{{p1, p0, id[5:0]}, 1'b0, 1'b0, n == 0});
		for (int i = 0; i < n; i++) begin
			b = word[12 + 8 * i +: 8];
			sum = sum + b;
			if (sum > 9'd255)
				sum = sum - 9'd255;
			beats_due.push_back('{b, 1'b0, 1'b0, 1'b0});
		end
		if (n != 0)
			beats_due.push_back('{~sum[7:0], 1'b0, 1'b0, 1'b1});
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= $urandom_range(99) >= recv_stall_pct;
			if (!s_tvalid || req_taken) begin
				if (send_idx < requests.size() && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= {4'b0, requests[send_idx].payload, requests[send_idx].len,
						requests[send_idx].id};
					s_tvalid <= 1'b1;
					send_idx <= send_idx + 1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		req_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			predict_frame(s_tdata);
		if (arst_n && m_tvalid && m_tready) begin
			if (beats_due.size() == 0) begin
				report_mismatch($sformatf("unexpected beat data %02h", m_tdata));
			end else begin
				frame_beat_t want;
				want = beats_due.pop_front();
				if (m_tdata !== want.data)
					report_mismatch($sformatf("byte %02h, wanted %02h", m_tdata, want.data));
				if (m_tuser[lmfb_pkg::USER_BREAK] !== want.brk)
					report_mismatch($sformatf("break flag %b, wanted %b",
						m_tuser[lmfb_pkg::USER_BREAK], want.brk));
				if (m_tuser[lmfb_pkg::USER_BAD] !== want.bad)
					report_mismatch($sformatf("bad id flag %b, wanted %b",
						m_tuser[lmfb_pkg::USER_BAD], want.bad));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("tlast %b, wanted %b", m_tlast, want.last));
			end
		end
	end

	task automatic add_req(input logic [7:0] id, input logic [3:0] len, input logic [63:0] pl);
		requests.push_back('{id, len, pl});
	endtask

	task automatic add_random_reqs(input int count);
		logic [7:0] id;
		logic [3:0] len;
		for (int i = 0; i < count; i++) begin
			id = ($urandom_range(99) < 85) ? 8'($urandom_range(63)) : 8'($urandom_range(255, 64));
			len = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
			add_req(id, len, {$urandom, $urandom});
		end
	endtask

	task automatic wait_drained;
		do
			@(negedge clk);
		while (send_idx != requests.size() || s_tvalid || beats_due.size() != 0);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		add_req(8'h00, 4'd0, 64'h0);
		add_req(8'h3f, 4'd0, 64'h0);
		add_req(8'h40, 4'd0, 64'h0);
		add_req(8'hff, 4'd8, '1);
		add_req(8'h80, 4'd3, 64'h0000_0000_0012_3456);
		add_req(8'h2a, 4'd1, 64'h0000_0000_0000_00a5);
		add_req(8'h15, 4'd2, 64'h0000_0000_0000_ff01);
		add_req(8'h3c, 4'd3, 64'hdead_beef_cafe_f00d);
		add_req(8'h01, 4'd4, 64'h0102_0304_0506_0708);
		add_req(8'h02, 4'd5, 64'hffff_ffff_ffff_ffff);
		add_req(8'h04, 4'd6, 64'h8080_8080_8080_8080);
		add_req(8'h08, 4'd7, 64'h0000_0000_0000_0000);
		add_req(8'h10, 4'd8, 64'hffff_ffff_ffff_ffff);
		add_req(8'h20, 4'd8, 64'h0000_0000_0000_0000);
		add_req(8'h3f, 4'd8, 64'h0102_0408_1020_4080);
		add_req(8'h33, 4'd9, 64'h5555_aaaa_5555_aaaa);
		add_req(8'h0f, 4'd15, 64'hfedc_ba98_7654_3210);
		add_req(8'h23, 4'd2, 64'hffff_ffff_ffff_00ff);
		add_req(8'h3e, 4'd1, 64'hffff_ffff_ffff_ff00);
		add_req(8'h00, 4'd8, 64'h7f7f_7f7f_7f7f_7f7f);
		add_random_reqs(40);
		wait_drained();

		send_idle_pct = 78;
		recv_stall_pct = 0;
		add_random_reqs(50);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 78;
		add_random_reqs(50);
		wait_drained();

		send_idle_pct = 28;
		recv_stall_pct = 28;
		add_random_reqs(60);
		wait_drained();

		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
